### rtl/lfms_pkg.sv
// shared types and constants for the line follow steering core
package lfms_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_MAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY         = 2'd3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_DATA_W-1:0] HOLD_RESET  = 16'd500;
    localparam logic [CFG_DATA_W-1:0] PHASE_RESET = 16'd750;

    // direction codes
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // Q2.14 command values
    localparam logic [15:0] Q_ONE      = 16'h4000;
    localparam logic [15:0] Q_NEG_ONE  = 16'hC000;
    localparam logic [15:0] Q_TURN     = 16'h3000;
    localparam logic [15:0] Q_NEG_TURN = 16'hD000;
    localparam logic [15:0] Q_ZERO     = 16'h0000;

    // input beat layout
    localparam int unsigned IN_TDATA_W   = 56;
    localparam int unsigned NOW_W        = 32;
    localparam int unsigned BIT_LINE_VLD = 32;
    localparam int unsigned OFF_LSB      = 33;
    localparam int unsigned BIT_STRAIGHT = 49;
    localparam int unsigned BIT_WARN     = 50;

    localparam int unsigned OUT_TDATA_W = 32;

    // result of one pass plus the state updates it asks for
    typedef struct packed {
        logic [15:0] steer_x;
        logic [15:0] drive_y;
        logic        line_hit;
        logic        straight_hit;
        logic        dir_load;
        logic [1:0]  dir_val;
    } steer_out_t;

endpackage

### rtl/line_follow_motor_steering_core.sv
// top level of the line follow steering core
// Takes one control tick per beat and returns one steering beat per tick. A new
// tick can be taken every cycle unless both registers are full and m_tready is
// low. A tick is captured in the input register, then a single pass of add and
// compare logic fills the result register, which raises m_tvalid. Stalls on the
// result side back up through the input register only when both are full.
// Configuration writes act on every tick that leaves the input register after
// the write edge, so write only while no tick is in flight; times are reduced
// to the low TIME_WIDTH bits and window limits never wrap.
module line_follow_motor_steering_core #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // now_ms[31:0], line_valid, line_offset[15:0], straight_seen, distance_warn
    input  logic [lfms_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // steer_x[15:0], drive_y[15:0]
    output logic [lfms_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_we,
    input  logic [lfms_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [lfms_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    logic [63:0]              now_full;
    logic [TIME_WIDTH-1:0]    now_trim;

    logic                     in_valid_reg;
    logic [TIME_WIDTH-1:0]    now_reg;
    logic                     lv_reg;
    logic signed [15:0]       off_reg;
    logic                     st_reg;
    logic                     warn_reg;
    logic                     advance;

    logic [15:0]              hold_reg, hold_next;
    logic [15:0]              turn_reg, turn_next;
    logic [15:0]              recov_reg, recov_next;
    logic [15:0]              retry_reg, retry_next;
    logic [16:0]              sum2_reg;
    logic [17:0]              sum3_reg;

    logic [1:0]               dir_reg;
    logic                     line_tv_reg;
    logic [TIME_WIDTH-1:0]    last_line_reg;
    logic                     str_tv_reg;
    logic [TIME_WIDTH-1:0]    last_str_reg;

    logic                     out_valid_reg;
    logic [15:0]              sx_reg;
    logic [15:0]              dy_reg;

    lfms_pkg::steer_out_t     res;

    assign now_full = {32'd0, s_tdata[lfms_pkg::NOW_W-1:0]};
    assign now_trim = now_full[TIME_WIDTH-1:0];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {dy_reg, sx_reg};

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            now_reg  <= now_trim;
            lv_reg   <= s_tdata[lfms_pkg::BIT_LINE_VLD];
            off_reg  <= s_tdata[lfms_pkg::OFF_LSB +: 16];
            st_reg   <= s_tdata[lfms_pkg::BIT_STRAIGHT];
            warn_reg <= s_tdata[lfms_pkg::BIT_WARN];
        end
    end

    // configuration, phase end offsets kept as running sums
    always_comb begin
        hold_next  = hold_reg;
        turn_next  = turn_reg;
        recov_next = recov_reg;
        retry_next = retry_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                lfms_pkg::CFG_STRAIGHT_HOLD: hold_next  = cfg_wdata;
                lfms_pkg::CFG_TURN_MAIN:     turn_next  = cfg_wdata;
                lfms_pkg::CFG_RECOVERY:      recov_next = cfg_wdata;
                lfms_pkg::CFG_RETRY:         retry_next = cfg_wdata;
                default:                     hold_next  = hold_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg  <= lfms_pkg::HOLD_RESET;
            turn_reg  <= lfms_pkg::PHASE_RESET;
            recov_reg <= lfms_pkg::PHASE_RESET;
            retry_reg <= lfms_pkg::PHASE_RESET;
            sum2_reg  <= 17'({1'b0, lfms_pkg::PHASE_RESET} + {1'b0, lfms_pkg::PHASE_RESET});
            sum3_reg  <= 18'({2'b00, lfms_pkg::PHASE_RESET} + {2'b00, lfms_pkg::PHASE_RESET}
                             + {2'b00, lfms_pkg::PHASE_RESET});
        end else begin
            hold_reg  <= hold_next;
            turn_reg  <= turn_next;
            recov_reg <= recov_next;
            retry_reg <= retry_next;
            sum2_reg  <= {1'b0, turn_next} + {1'b0, recov_next};
            sum3_reg  <= {2'b00, turn_next} + {2'b00, recov_next} + {2'b00, retry_next};
        end
    end

    lfms_steer #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_steer (
        .now           (now_reg),
        .line_valid    (lv_reg),
        .line_offset   (off_reg),
        .straight_seen (st_reg),
        .distance_warn (warn_reg),
        .hold_ms       (hold_reg),
        .turn_sum      (turn_reg),
        .recov_sum     (sum2_reg),
        .retry_sum     (sum3_reg),
        .dir           (dir_reg),
        .line_tv       (line_tv_reg),
        .last_line     (last_line_reg),
        .str_tv        (str_tv_reg),
        .last_str      (last_str_reg),
        .res           (res)
    );

    // tracking state moves with each tick leaving the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg       <= lfms_pkg::DIR_NONE;
            line_tv_reg   <= 1'b0;
            last_line_reg <= '0;
            str_tv_reg    <= 1'b0;
            last_str_reg  <= '0;
        end else if (advance) begin
            if (res.dir_load) begin
                dir_reg <= res.dir_val;
            end
            if (res.line_hit) begin
                line_tv_reg   <= 1'b1;
                last_line_reg <= now_reg;
            end
            if (res.straight_hit) begin
                str_tv_reg   <= 1'b1;
                last_str_reg <= now_reg;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sx_reg <= res.steer_x;
            dy_reg <= res.drive_y;
        end
    end

endmodule

### rtl/lfms_steer.sv
// steering decision for one control tick
module lfms_steer #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic [TIME_WIDTH-1:0]     now,
    input  logic                      line_valid,
    input  logic signed [15:0]        line_offset,
    input  logic                      straight_seen,
    input  logic                      distance_warn,
    input  logic [15:0]               hold_ms,
    input  logic [15:0]               turn_sum,
    input  logic [16:0]               recov_sum,
    input  logic [17:0]               retry_sum,
    input  logic [1:0]                dir,
    input  logic                      line_tv,
    input  logic [TIME_WIDTH-1:0]     last_line,
    input  logic                      str_tv,
    input  logic [TIME_WIDTH-1:0]     last_str,
    output lfms_pkg::steer_out_t      res
);

    localparam int unsigned SUM_W = TIME_WIDTH + 3;

    logic [SUM_W-1:0]      now_x;
    logic [TIME_WIDTH-1:0] str_time;
    logic                  str_valid;
    logic [SUM_W-1:0]      hold_lim;
    logic [SUM_W-1:0]      lim1;
    logic [SUM_W-1:0]      lim2;
    logic [SUM_W-1:0]      lim3;
    logic                  in_hold;
    logic                  dir_known;
    logic [15:0]           toward;
    logic [15:0]           away;
    logic signed [15:0]    off_q4;
    logic signed [15:0]    off_q2;

    // sums are wide enough never to wrap, so no saturation needed
    assign now_x     = {3'b000, now};
    assign str_valid = str_tv | straight_seen;
    assign str_time  = straight_seen ? now : last_str;
    assign hold_lim  = {3'b000, str_time} + {{(SUM_W-16){1'b0}}, hold_ms};
    assign lim1      = {3'b000, last_line} + {{(SUM_W-16){1'b0}}, turn_sum};
    assign lim2      = {3'b000, last_line} + {{(SUM_W-17){1'b0}}, recov_sum};
    assign lim3      = {3'b000, last_line} + {{(SUM_W-18){1'b0}}, retry_sum};
    assign in_hold   = str_valid && (hold_lim >= now_x);

    assign off_q4 = line_offset >>> 2;
    assign off_q2 = line_offset >>> 1;

    assign dir_known = line_tv && (dir == lfms_pkg::DIR_RIGHT || dir == lfms_pkg::DIR_LEFT);
    assign toward = (dir == lfms_pkg::DIR_RIGHT) ? lfms_pkg::Q_TURN : lfms_pkg::Q_NEG_TURN;
    assign away   = (dir == lfms_pkg::DIR_RIGHT) ? lfms_pkg::Q_NEG_TURN : lfms_pkg::Q_TURN;

    always_comb begin
        res              = '0;
        res.steer_x      = lfms_pkg::Q_ZERO;
        res.drive_y      = lfms_pkg::Q_ZERO;
        if (distance_warn) begin
            res.steer_x = lfms_pkg::Q_ZERO;
        end else if (line_valid) begin
            res.line_hit     = 1'b1;
            res.straight_hit = straight_seen;
            res.dir_load     = (line_offset != 16'sd0);
            res.dir_val      = line_offset[15] ? lfms_pkg::DIR_LEFT : lfms_pkg::DIR_RIGHT;
            res.steer_x      = in_hold ? off_q4 : off_q2;
            res.drive_y      = lfms_pkg::Q_ONE;
        end else if (dir_known) begin
            if (lim1 >= now_x) begin
                res.steer_x = toward;
                res.drive_y = lfms_pkg::Q_ONE;
            end else if (lim2 >= now_x) begin
                res.steer_x = toward;
                res.drive_y = lfms_pkg::Q_NEG_ONE;
            end else if (lim3 >= now_x) begin
                res.steer_x = away;
                res.drive_y = lfms_pkg::Q_ONE;
            end
        end
    end

endmodule

### rtl/lfms_chk.sv
// port level checks for the line follow steering core
module lfms_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [lfms_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat shown right after reset");

    // with nothing waiting at the output the input side must be open
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // drive is only forward, reverse or stop
    a_drive_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:16] == lfms_pkg::Q_ONE
                   || m_tdata[31:16] == lfms_pkg::Q_NEG_ONE
                   || m_tdata[31:16] == lfms_pkg::Q_ZERO))
        else $error("drive value outside forward, reverse, stop");

    // stop means no steering
    a_stop_steer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31:16] == lfms_pkg::Q_ZERO |-> m_tdata[15:0] == lfms_pkg::Q_ZERO)
        else $error("steering while stopped");

    // a stalled result beat stays put
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

endmodule

bind line_follow_motor_steering_core lfms_chk u_lfms_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
